>>> sv/msbr_pkg.sv
// Shared types, widths and codes for the MSB-first bit reader.
// No dependencies; every other file refers to it by scoped names.
package msbr_pkg;

  localparam int MAX_BYTES_DEF = 1024;
  localparam int VALUE_W       = 64;
  localparam int COUNT_W       = 7;
  localparam int OP_W          = 2;
  localparam int STATUS_W      = 2;
  localparam int BYTE_W        = 8;
  localparam int READ_MAX      = 64;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PAST_END  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_COUNT = 2'd3;

  typedef struct packed {
    logic               shift;
    logic [2:0]         tail;
    logic [COUNT_W-1:0] count;
  } gather_ctl_t;

endpackage

>>> sv/msbr_req_if.sv
// Request channel of the bit reader: valid/ready plus op, byte and bit count.
// Depends on msbr_pkg.
interface msbr_req_if;
  logic                       valid;
  logic                       ready;
  logic [msbr_pkg::OP_W-1:0]    op;
  logic [msbr_pkg::BYTE_W-1:0]  byte_in;
  logic [msbr_pkg::COUNT_W-1:0] bit_count;

  modport source (output valid, op, byte_in, bit_count, input ready);
  modport sink   (input valid, op, byte_in, bit_count, output ready);
endinterface

>>> sv/msbr_res_if.sv
// Result channel of the bit reader: valid/ready plus value and status.
// Depends on msbr_pkg.
interface msbr_res_if;
  logic                        valid;
  logic                        ready;
  logic [msbr_pkg::VALUE_W-1:0]  value;
  logic [msbr_pkg::STATUS_W-1:0] status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

>>> sv/msbr_gather.sv
// Byte-serial gather register: shifts in one fetched byte per cycle while shift is set, then
// drops the trailing bits and masks to the requested count. Depends on msbr_pkg.
module msbr_gather (
  input  logic                          clk,
  input  msbr_pkg::gather_ctl_t         ctl,
  input  logic [msbr_pkg::BYTE_W-1:0]   byte_data,
  output logic [msbr_pkg::VALUE_W-1:0]  value
);

  localparam int ACC_W = msbr_pkg::VALUE_W + msbr_pkg::BYTE_W;

  logic [ACC_W-1:0]             acc;
  logic [ACC_W-1:0]             shifted;
  logic [msbr_pkg::VALUE_W-1:0] mask;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      acc <= {acc[ACC_W-msbr_pkg::BYTE_W-1:0], byte_data};
    end
  end

  always_comb begin
    shifted = acc >> ctl.tail;
    for (int i = 0; i < msbr_pkg::VALUE_W; i++) begin
      mask[i] = (i < int'(ctl.count));
    end
    value = shifted[msbr_pkg::VALUE_W-1:0] & mask;
  end

endmodule

>>> sv/msb_first_bit_reader_core.sv
// Top level of the MSB-first bit reader: byte store, length and bit pointer,
// request decode and fetch sequencer. Depends on msbr_pkg, msbr_req_if,
// msbr_res_if and msbr_gather.
//
// Clear, append, unused-op, zero-length and rejected read requests finish in
// the cycle after acceptance. A read of n bits starting at bit p touches
// k = ((p+n-1)>>3) - (p>>3) + 1 bytes (1..9), fetched one byte per cycle from
// the single-port byte memory in the fetch state; drain waits for the last
// read data and done aligns and masks the result. A request is taken when
// the sequencer is idle and the result register is empty or being emptied.
module msb_first_bit_reader_core #(
  parameter int MAX_BYTES = msbr_pkg::MAX_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  msbr_req_if.sink   req,
  msbr_res_if.source res
);

  localparam int LEN_W  = $clog2(MAX_BYTES + 1);
  localparam int PTR_W  = LEN_W + 3;
  localparam int ADDR_W = $clog2(MAX_BYTES);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [msbr_pkg::BYTE_W-1:0] mem [MAX_BYTES];

  logic [1:0]                   state;
  logic [LEN_W-1:0]             length;
  logic [PTR_W-1:0]             pointer;
  logic [ADDR_W-1:0]            raddr;
  logic [3:0]                   issue_left;
  logic                         rd_valid;
  logic [msbr_pkg::BYTE_W-1:0]  rd_data;
  logic [2:0]                   rd_tail;
  logic [msbr_pkg::COUNT_W-1:0] rd_count;
  logic                         res_valid;

  logic                           slot_free;
  logic                           accept;
  logic                           full;
  logic [PTR_W:0]                 end_bit;
  logic [PTR_W:0]                 end_m1;
  logic [LEN_W:0]                 span;
  logic                           start_read;
  logic [msbr_pkg::STATUS_W-1:0]  imm_status;
  logic                           fire_imm;
  logic                           fire_done;
  msbr_pkg::gather_ctl_t          gctl;
  logic [msbr_pkg::VALUE_W-1:0]   gvalue;

  assign slot_free = !res_valid || res.ready;
  assign req.ready = (state == S_IDLE) && slot_free;
  assign accept    = req.valid && req.ready;
  assign res.valid = res_valid;

  assign full    = (length == LEN_W'(MAX_BYTES));
  assign end_bit = {1'b0, pointer} + (PTR_W + 1)'(req.bit_count);
  assign end_m1  = end_bit - 1'b1;
  assign span    = end_m1[PTR_W:3] - {1'b0, pointer[PTR_W-1:3]};

  always_comb begin
    start_read = 1'b0;
    imm_status = msbr_pkg::ST_OK;
    case (req.op)
      msbr_pkg::OP_APPEND: begin
        if (full) imm_status = msbr_pkg::ST_FULL;
      end
      msbr_pkg::OP_READ: begin
        if (req.bit_count > msbr_pkg::COUNT_W'(msbr_pkg::READ_MAX)) begin
          imm_status = msbr_pkg::ST_BAD_COUNT;
        end else if (end_bit > (PTR_W + 1)'({length, 3'b000})) begin
          imm_status = msbr_pkg::ST_PAST_END;
        end else if (req.bit_count != '0) begin
          start_read = 1'b1;
        end
      end
      default: imm_status = msbr_pkg::ST_OK;
    endcase
  end

  assign fire_imm  = accept && !start_read;
  assign fire_done = (state == S_DONE) && slot_free;

  always_ff @(posedge clk) begin
    if (accept && req.op == msbr_pkg::OP_APPEND && !full) begin
      mem[length[ADDR_W-1:0]] <= req.byte_in;
    end
    rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      length    <= '0;
      pointer   <= '0;
      rd_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      rd_valid <= (state == S_FETCH);
      if (fire_imm || fire_done) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req.op)
              msbr_pkg::OP_CLEAR: begin
                length  <= '0;
                pointer <= '0;
              end
              msbr_pkg::OP_APPEND: begin
                if (!full) length <= length + 1'b1;
              end
              default: begin
                if (start_read) begin
                  pointer <= end_bit[PTR_W-1:0];
                  state   <= S_FETCH;
                end
              end
            endcase
          end
        end
        S_FETCH: begin
          if (issue_left == 4'd1) state <= S_DRAIN;
        end
        S_DRAIN: state <= S_DONE;
        S_DONE: begin
          if (slot_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && start_read) begin
      raddr      <= pointer[ADDR_W+2:3];
      issue_left <= span[3:0] + 4'd1;
      rd_tail    <= 3'd0 - end_bit[2:0];
      rd_count   <= req.bit_count;
    end else if (state == S_FETCH) begin
      raddr      <= raddr + 1'b1;
      issue_left <= issue_left - 4'd1;
    end
    if (fire_imm) begin
      res.value  <= '0;
      res.status <= imm_status;
    end else if (fire_done) begin
      res.value  <= gvalue;
      res.status <= msbr_pkg::ST_OK;
    end
  end

  assign gctl.shift = rd_valid;
  assign gctl.tail  = rd_tail;
  assign gctl.count = rd_count;

  msbr_gather u_gather (
    .clk       (clk),
    .ctl       (gctl),
    .byte_data (rd_data),
    .value     (gvalue)
  );

endmodule
